// ----- rtl/bpcb_pkg.sv -----
// Shared types, constants and layout helpers for the pixel convert/blend blit stage.
`timescale 1ns / 1ps
`default_nettype none

package bpcb_pkg;

    localparam int unsigned CHAN_BITS = 8;
    localparam int unsigned LAYOUT_W  = 42;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [7:0]  OPAQUE    = 8'd255;
    // ceil(2^23 / 255): x * RECIP_255 >> 23 equals x / 255 for any 16-bit x
    localparam logic [15:0] RECIP_255 = 16'd32897;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LAYOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_LAYOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_ALPHA = 3'd4;

    // One channel of a pixel layout, width already saturated to 8
    typedef struct packed {
        logic [31:0] mask;
        logic [4:0]  shift;
        logic [3:0]  width;
    } chan_fmt_t;

    // Channel order r, g, b, a
    typedef struct packed {
        chan_fmt_t [3:0] chan;
        logic [5:0]      bpp;
    } layout_t;

    // Load strobes for the blend lanes
    typedef struct packed {
        logic load_sum;
        logic load_quo;
    } lane_ctl_t;

    function automatic layout_t decode_layout(input logic [LAYOUT_W-1:0] word);
        layout_t    lay;
        logic [8:0] fld;
        logic [3:0] w;
        logic [8:0] ones;
        for (int c = 0; c < 4; c++) begin
            fld  = word[9*c +: 9];
            w    = (fld[8:5] > 4'd8) ? 4'd8 : fld[8:5];
            ones = (9'd1 << w) - 9'd1;
            lay.chan[c].width = w;
            lay.chan[c].shift = fld[4:0];
            lay.chan[c].mask  = {24'd0, ones[7:0]} << fld[4:0];
        end
        lay.bpp = word[41:36];
        return lay;
    endfunction

    // Extract a channel and scale it up to 8 bits
    function automatic logic [7:0] unpack_chan(input logic [31:0] pix, input chan_fmt_t f);
        logic [31:0] v;
        logic [3:0]  sh;
        logic [7:0]  r;
        v  = (pix & f.mask) >> f.shift;
        sh = 4'd8 - f.width;
        r  = v[7:0] << sh[2:0];
        if (f.width == 4'd0)
        begin
            r = 8'd0;
        end
        return r;
    endfunction

    // Scale an 8-bit channel down to the field width and place it
    function automatic logic [31:0] pack_chan(input logic [7:0] v, input chan_fmt_t f);
        logic [3:0]  sh;
        logic [7:0]  t;
        logic [31:0] r;
        sh = 4'd8 - f.width;
        t  = v >> sh[2:0];
        r  = ({24'd0, t} << f.shift) & f.mask;
        if (f.width == 4'd0)
        begin
            r = 32'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bpcb_blend_lane.sv -----
// One color lane of the blend: weighted sum, then divide by 255 via reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module bpcb_blend_lane
    import bpcb_pkg::*;
(
    input  wire logic      clk,
    input  wire lane_ctl_t ctl,
    input  wire logic [7:0] s,
    input  wire logic [7:0] d,
    input  wire logic [7:0] a,
    output logic [7:0]      quo
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  quo_reg;
    logic [7:0]  quo_next;
    logic [15:0] prod_s;
    logic [15:0] prod_d;
    logic [7:0]  inv_a;
    logic [31:0] scaled;

    // s*a + d*(255-a), at most 255*255 so it fits 16 bits
    always_comb
    begin
        inv_a    = OPAQUE - a;
        prod_s   = {8'd0, s} * {8'd0, a};
        prod_d   = {8'd0, d} * {8'd0, inv_a};
        sum_next = prod_s + prod_d;
    end

    // Exact floor(sum / 255) for any sum up to 255*255
    always_comb
    begin
        scaled   = {16'd0, sum_reg} * {16'd0, RECIP_255};
        quo_next = scaled[30:23];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.load_quo)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/blit_pixel_convert_blend_top.sv -----
// Top level of the pixel convert/blend blit stage: config registers and 5-stage pipeline.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata: source_pixel, dest_pixel
//  m_*     | out | m_tvalid / m_tready    | m_tdata: write_enable, new_pixel, zero pad
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (register write)
//
//  One request per cycle sustained while m_tready stays high.
//  Stages: input reg, unpack/classify, blend sums, divide by 255, pack to output reg.
//  Each stage holds while its successor is full and stalled; bubbles are squeezed out.
//  rst_n clears the stage valid bits and the config registers (surface alpha to 255).
//  cfg_ready is always high; the user must change config only while the pipeline is empty (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module blit_pixel_convert_blend_top
    import bpcb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata,   // [0] write_enable, [32:1] new_pixel, [39:33] 0
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LAYOUT_W-1:0]  cfg_data
);

    typedef struct packed {
        logic pass;
        logic drop;
        logic blend;
    } route_t;

    // Configuration registers
    logic [LAYOUT_W-1:0] source_layout_reg;
    logic [LAYOUT_W-1:0] dest_layout_reg;
    logic [31:0]         color_key_reg;
    logic [1:0]          blit_mode_reg;
    logic [7:0]          surface_alpha_reg;

    // Pipeline control, bit k is stage k+1
    logic [4:0] valid_reg;
    logic [4:0] stage_en;

    // Stage 1
    logic [31:0] src_1_reg;
    logic [31:0] dst_1_reg;
    // Stage 2
    logic [31:0]     src_2_reg;
    logic [2:0][7:0] sch_2_reg;
    logic [2:0][7:0] dch_2_reg;
    logic [7:0]      a_2_reg;
    logic [7:0]      da_2_reg;
    route_t          route_2_reg;
    // Stage 3
    logic [31:0]     src_3_reg;
    logic [2:0][7:0] col_3_reg;
    logic [7:0]      alpha_3_reg;
    route_t          route_3_reg;
    // Stage 4
    logic [31:0]     src_4_reg;
    logic [2:0][7:0] col_4_reg;
    logic [7:0]      alpha_4_reg;
    route_t          route_4_reg;
    // Stage 5 (output)
    logic        we_5_reg;
    logic [31:0] pix_5_reg;

    layout_t         src_lay;
    layout_t         dst_lay;
    logic [3:0][7:0] sch_1;
    logic [3:0][7:0] dch_1;
    logic            key_on;
    logic            alpha_on;
    logic            same;
    logic [7:0]      a_1;
    logic [7:0]      da_1;
    route_t          route_1;
    logic [7:0]      alpha_2;
    logic [2:0][7:0] quo_4;
    logic [3:0][7:0] ch_4;
    logic [31:0]     pix_4;
    logic            we_4;
    logic [31:0]     pix_out_4;
    lane_ctl_t       lane_ctl;

    // Config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_layout_reg <= '0;
            dest_layout_reg   <= '0;
            color_key_reg     <= '0;
            blit_mode_reg     <= '0;
            surface_alpha_reg <= OPAQUE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOURCE_LAYOUT: source_layout_reg <= cfg_data;
                REG_DEST_LAYOUT:   dest_layout_reg   <= cfg_data;
                REG_COLOR_KEY:     color_key_reg     <= cfg_data[31:0];
                REG_BLIT_MODE:     blit_mode_reg     <= cfg_data[1:0];
                REG_SURFACE_ALPHA: surface_alpha_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        stage_en[4] = !valid_reg[4] || m_tready;
        for (int k = 3; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[4];
    assign m_tdata  = {7'd0, pix_5_reg, we_5_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < 5; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: unpack both pixels, key compare, alpha source, routing
    always_comb
    begin
        src_lay  = decode_layout(source_layout_reg);
        dst_lay  = decode_layout(dest_layout_reg);
        key_on   = blit_mode_reg[0];
        alpha_on = blit_mode_reg[1];
        same     = (src_lay.bpp == dst_lay.bpp);
        for (int c = 0; c < 4; c++)
        begin
            sch_1[c] = unpack_chan(src_1_reg, src_lay.chan[c]);
            dch_1[c] = unpack_chan(dst_1_reg, dst_lay.chan[c]);
            if (src_lay.chan[c].mask != dst_lay.chan[c].mask)
            begin
                same = 1'b0;
            end
        end
        // Pixel alpha only when blending and the source carries alpha
        if (alpha_on && src_lay.chan[3].width != 4'd0)
        begin
            a_1 = sch_1[3];
        end
        else if (alpha_on)
        begin
            a_1 = surface_alpha_reg;
        end
        else
        begin
            a_1 = OPAQUE;
        end
        da_1 = (dst_lay.chan[3].width != 4'd0) ? dch_1[3] : OPAQUE;
        route_1.pass  = !key_on && !alpha_on && same;
        route_1.drop  = !route_1.pass &&
                        ((key_on && src_1_reg == color_key_reg) || (alpha_on && a_1 == 8'd0));
        route_1.blend = alpha_on && a_1 != OPAQUE;
    end

    // Stage 2 alpha: larger of source and destination when blending
    always_comb
    begin
        alpha_2 = a_2_reg;
        if (route_2_reg.blend && da_2_reg > a_2_reg)
        begin
            alpha_2 = da_2_reg;
        end
    end

    // Blend lanes span stages 3 and 4
    assign lane_ctl.load_sum = stage_en[2];
    assign lane_ctl.load_quo = stage_en[3];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        bpcb_blend_lane u_lane (
            .clk (clk),
            .ctl (lane_ctl),
            .s   (sch_2_reg[c]),
            .d   (dch_2_reg[c]),
            .a   (a_2_reg),
            .quo (quo_4[c])
        );
    end

    // Stage 4: pick blended or plain channels, pack into destination layout, then apply pass or drop
    always_comb
    begin
        ch_4[3] = alpha_4_reg;
        for (int c = 0; c < 3; c++)
        begin
            ch_4[c] = route_4_reg.blend ? quo_4[c] : col_4_reg[c];
        end
        pix_4 = 32'd0;
        for (int c = 0; c < 4; c++)
        begin
            pix_4 = pix_4 | pack_chan(ch_4[c], dst_lay.chan[c]);
        end
        if (route_4_reg.pass)
        begin
            we_4      = 1'b1;
            pix_out_4 = src_4_reg;
        end
        else if (route_4_reg.drop)
        begin
            we_4      = 1'b0;
            pix_out_4 = 32'd0;
        end
        else
        begin
            we_4      = 1'b1;
            pix_out_4 = pix_4;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            src_1_reg <= s_tdata[31:0];
            dst_1_reg <= s_tdata[63:32];
        end
        if (stage_en[1])
        begin
            src_2_reg   <= src_1_reg;
            sch_2_reg   <= sch_1[2:0];
            dch_2_reg   <= dch_1[2:0];
            a_2_reg     <= a_1;
            da_2_reg    <= da_1;
            route_2_reg <= route_1;
        end
        if (stage_en[2])
        begin
            src_3_reg   <= src_2_reg;
            col_3_reg   <= sch_2_reg;
            alpha_3_reg <= alpha_2;
            route_3_reg <= route_2_reg;
        end
        if (stage_en[3])
        begin
            src_4_reg   <= src_3_reg;
            col_4_reg   <= col_3_reg;
            alpha_4_reg <= alpha_3_reg;
            route_4_reg <= route_3_reg;
        end
        if (stage_en[4])
        begin
            we_5_reg  <= we_4;
            pix_5_reg <= pix_out_4;
        end
    end

    // A stalled stage keeps its request
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg & ~stage_en)) == $past(valid_reg & ~stage_en)))
        else $error("stalled pipeline stage lost its request");

    // Full pipeline with a stalled output takes nothing new
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == 5'b11111 && !m_tready) |-> !s_tready)
        else $error("input accepted into a full stalled pipeline");

    // A dropped pixel carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
        else $error("dropped pixel with nonzero value");

endmodule

`default_nettype wire

// ----- tb/blit_pixel_convert_blend_top_test.sv -----
// Self-checking testbench for the pixel convert/blend blit stage with its own pixel predictor.
`timescale 1ns / 1ps

module blit_pixel_convert_blend_top_test;
    import bpcb_pkg::*;

    // blit_mode codes
    localparam logic [1:0] MODE_COPY      = 2'd0;
    localparam logic [1:0] MODE_KEY       = 2'd1;
    localparam logic [1:0] MODE_BLEND     = 2'd2;
    localparam logic [1:0] MODE_KEY_BLEND = 2'd3;

    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned MAX_REPORTS = 10;

    // Decoded pixel layout, channel order r, g, b, a
    typedef struct packed {
        logic [3:0][31:0] mask;
        logic [3:0][4:0]  shift;
        logic [3:0][3:0]  width;
        logic [5:0]       bpp;
    } fmt_t;

    typedef struct packed {
        logic [31:0] dst;
        logic [31:0] src;
    } pixel_pair_t;

    typedef struct packed {
        logic        we;
        logic [31:0] pix;
    } pix_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;  // [31:0] source_pixel, [63:32] dest_pixel
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;         // [0] write_enable, [32:1] new_pixel, [39:33] 0
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LAYOUT_W-1:0]  cfg_data  = '0;

    // Shadow copy of the register file
    logic [LAYOUT_W-1:0] src_fmt_reg    = '0;
    logic [LAYOUT_W-1:0] dst_fmt_reg    = '0;
    logic [31:0]         key_reg        = '0;
    logic [1:0]          mode_reg       = MODE_COPY;
    logic [7:0]          surf_alpha_reg = OPAQUE;

    pixel_pair_t pixel_pairs_q[$];
    pix_result_t pixel_results_q[$];
    pixel_pair_t next_pair;
    pix_result_t want;

    int unsigned pairs_issued   = 0;
    int unsigned pairs_sent     = 0;
    int unsigned pixels_checked = 0;
    int unsigned pixels_written = 0;
    int unsigned error_count    = 0;
    int unsigned setup_count    = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;

    logic [LAYOUT_W-1:0] known_fmts [6];

    blit_pixel_convert_blend_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- pixel predictor ----------------

    function automatic fmt_t decode_fmt(input logic [LAYOUT_W-1:0] word);
        fmt_t        f;
        logic [3:0]  w;
        logic [31:0] ones;
        for (int c = 0; c < 4; c++)
        begin
            w = word[9*c+5 +: 4];
            if (w > 4'd8)
            begin
                w = 4'd8;
            end
            ones       = (32'd1 << w) - 32'd1;
            f.width[c] = w;
            f.shift[c] = word[9*c +: 5];
            f.mask[c]  = ones << f.shift[c];
        end
        f.bpp = word[41:36];
        return f;
    endfunction

    // Field value scaled up to 8 bits
    function automatic logic [7:0] chan_to_8(input fmt_t f, input int c, input logic [31:0] pix);
        logic [31:0] v;
        if (f.width[c] == 4'd0)
        begin
            return 8'd0;
        end
        v = ((pix & f.mask[c]) >> f.shift[c]) << (4'd8 - f.width[c]);
        return v[7:0];
    endfunction

    // 8-bit value cut down to the field width and placed
    function automatic logic [31:0] chan_from_8(input fmt_t f, input int c, input logic [7:0] v);
        logic [31:0] t;
        if (f.width[c] == 4'd0)
        begin
            return 32'd0;
        end
        t = {24'd0, v >> (4'd8 - f.width[c])};
        return (t << f.shift[c]) & f.mask[c];
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
        int unsigned acc;
        acc = s * a + d * (OPAQUE - a);
        return 8'(acc / 255);
    endfunction

    function automatic pix_result_t convert_pixel(input logic [31:0] src, input logic [31:0] dst);
        fmt_t            sf;
        fmt_t            df;
        logic [3:0][7:0] ch;
        logic [7:0]      a;
        logic [7:0]      da;
        logic            key_on;
        logic            blend_on;
        pix_result_t     r;
        sf       = decode_fmt(src_fmt_reg);
        df       = decode_fmt(dst_fmt_reg);
        key_on   = (mode_reg & MODE_KEY) != 2'd0;
        blend_on = (mode_reg & MODE_BLEND) != 2'd0;
        r.we     = 1'b0;
        r.pix    = 32'd0;
        // identical packing with nothing to do: raw copy
        if (!key_on && !blend_on && sf.bpp == df.bpp && sf.mask == df.mask)
        begin
            r.we  = 1'b1;
            r.pix = src;
            return r;
        end
        if (key_on && src == key_reg)
        begin
            return r;
        end
        for (int c = 0; c < 4; c++)
        begin
            ch[c] = chan_to_8(sf, c, src);
        end
        if (!(blend_on && sf.width[3] != 4'd0))
        begin
            ch[3] = blend_on ? surf_alpha_reg : OPAQUE;
        end
        if (blend_on && ch[3] != OPAQUE)
        begin
            a = ch[3];
            if (a == 8'd0)
            begin
                return r;
            end
            for (int c = 0; c < 3; c++)
            begin
                ch[c] = mix_chan(ch[c], chan_to_8(df, c, dst), a);
            end
            da    = (df.width[3] != 4'd0) ? chan_to_8(df, 3, dst) : OPAQUE;
            ch[3] = (da > a) ? da : a;
        end
        r.we = 1'b1;
        for (int c = 0; c < 4; c++)
        begin
            r.pix = r.pix | chan_from_8(df, c, ch[c]);
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [LAYOUT_W-1:0] make_fmt(
        input int r_sh, input int r_w, input int g_sh, input int g_w,
        input int b_sh, input int b_w, input int a_sh, input int a_w, input int bpp);
        logic [LAYOUT_W-1:0] word;
        word = '0;
        word[4:0]   = 5'(r_sh);
        word[8:5]   = 4'(r_w);
        word[13:9]  = 5'(g_sh);
        word[17:14] = 4'(g_w);
        word[22:18] = 5'(b_sh);
        word[26:23] = 4'(b_w);
        word[31:27] = 5'(a_sh);
        word[35:32] = 4'(a_w);
        word[41:36] = 6'(bpp);
        return word;
    endfunction

    function automatic logic [LAYOUT_W-1:0] pick_fmt();
        if ($urandom_range(2) != 0)
        begin
            return known_fmts[$urandom_range(5)];
        end
        return {10'($urandom), 32'($urandom)};
    endfunction

    // Force the source alpha field to a given 8-bit level
    function automatic logic [31:0] with_alpha(input logic [31:0] pix, input logic [7:0] a);
        fmt_t f;
        f = decode_fmt(src_fmt_reg);
        return (pix & ~f.mask[3]) | chan_from_8(f, 3, a);
    endfunction

    function automatic logic steady(input int unsigned n);
        return n >= 500 && n < 700;
    endfunction

    // Called at a rising edge; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LAYOUT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_SOURCE_LAYOUT: src_fmt_reg    = val;
            REG_DEST_LAYOUT:   dst_fmt_reg    = val;
            REG_COLOR_KEY:     key_reg        = val[31:0];
            REG_BLIT_MODE:     mode_reg       = val[1:0];
            REG_SURFACE_ALPHA: surf_alpha_reg = val[7:0];
            default:           ;
        endcase
    endtask

    // Upper data bits are don't-care for the narrow registers, so fill them with noise
    task automatic load_setup(input logic [LAYOUT_W-1:0] sl, input logic [LAYOUT_W-1:0] dl,
                              input logic [31:0] key, input logic [1:0] mode,
                              input logic [7:0] alpha);
        write_reg(REG_SOURCE_LAYOUT, sl);
        write_reg(REG_DEST_LAYOUT, dl);
        write_reg(REG_COLOR_KEY, {10'($urandom), key});
        write_reg(REG_BLIT_MODE, {40'({$urandom, $urandom}), mode});
        write_reg(REG_SURFACE_ALPHA, {34'({$urandom, $urandom}), alpha});
        cfg_valid <= 1'b0;
        setup_count++;
    endtask

    task automatic push_pair(input logic [31:0] src, input logic [31:0] dst);
        pixel_pairs_q.push_back('{dst: dst, src: src});
        pairs_issued++;
    endtask

    // Wait until every request has come back, then let the pipeline drain
    task automatic settle();
        wait (pixels_checked >= pairs_issued);
        repeat (8) @(posedge clk);
    endtask

    // ---------------- request driver ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pixel_results_q.push_back(convert_pixel(s_tdata[31:0], s_tdata[63:32]));
                pairs_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pixel_pairs_q.size() != 0 &&
                    (steady(pairs_sent) || $urandom_range(99) >= 15))
                begin
                    next_pair = pixel_pairs_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_pair.dst, next_pair.src};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- long receiver hold ----------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (rst_n && !hold_done && pixels_checked >= 250)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixel_results_q.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result we=%0b pix=%08h",
                                 $realtime, m_tdata[0], m_tdata[32:1]);
                    end
                    error_count++;
                end
                else
                begin
                    want = pixel_results_q.pop_front();
                    if (m_tdata[0] !== want.we || m_tdata[32:1] !== want.pix)
                    begin
                        if (error_count < MAX_REPORTS)
                        begin
                            $display({"%0t: result %0d mismatch: ",
                                      "we exp %0b got %0b, pix exp %08h got %08h"},
                                     $realtime, pixels_checked, want.we, m_tdata[0],
                                     want.pix, m_tdata[32:1]);
                        end
                        error_count++;
                    end
                end
                if (m_tdata[0])
                begin
                    pixels_written++;
                end
                pixels_checked++;
            end
            // stall through the long hold, otherwise random stalls
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady(pixels_checked) || $urandom_range(99) >= 15;
            end
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        logic [LAYOUT_W-1:0] sl;
        logic [LAYOUT_W-1:0] dl;
        logic [31:0]         key;
        logic [7:0]          alpha;
        logic [31:0]         src;
        logic [LAYOUT_W-1:0] argb8888;
        logic [LAYOUT_W-1:0] rgb565;
        logic [LAYOUT_W-1:0] rgb888;
        logic [LAYOUT_W-1:0] argb1555;
        logic [LAYOUT_W-1:0] argb4444;

        argb8888 = make_fmt(16, 8, 8, 8, 0, 8, 24, 8, 32);
        rgb565   = make_fmt(11, 5, 5, 6, 0, 5, 0, 0, 16);
        rgb888   = make_fmt(16, 8, 8, 8, 0, 8, 0, 0, 24);
        argb1555 = make_fmt(10, 5, 5, 5, 0, 5, 15, 1, 16);
        argb4444 = make_fmt(8, 4, 4, 4, 0, 4, 12, 4, 16);
        known_fmts[0] = argb8888;
        known_fmts[1] = make_fmt(0, 8, 8, 8, 16, 8, 24, 8, 32);
        known_fmts[2] = rgb565;
        known_fmts[3] = rgb888;
        known_fmts[4] = argb1555;
        known_fmts[5] = argb4444;

        wait (rst_n);
        @(posedge clk);

        // reset values: empty layouts match, so pixels copy straight through
        push_pair(32'h0000_0000, 32'h0000_0000);
        push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A);

        // per-pixel alpha with color key: key drop, zero alpha, opaque, blends
        settle();
        load_setup(argb8888, rgb565, 32'hFF00_FF00, MODE_KEY_BLEND, 8'd128);
        push_pair(32'hFF00_FF00, 32'h0000_1234);
        push_pair(32'h00FF_FFFF, 32'h0000_FFFF);
        push_pair(32'hFF10_2030, 32'h0000_FFFF);
        push_pair(32'h80FF_8040, 32'h0000_0000);
        push_pair(32'h80FF_8040, 32'h0000_FFFF);
        push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_pair(32'h0000_0000, 32'h0000_0000);

        // no source alpha, surface alpha zero: every pixel dropped
        settle();
        load_setup(rgb888, argb8888, 32'h0000_0000, MODE_BLEND, 8'd0);
        push_pair(32'h0012_3456, 32'hFFFF_FFFF);
        push_pair(32'hFFFF_FFFF, 32'h0000_0000);

        // key only, all-ones key, conversion to 4-bit channels
        settle();
        load_setup(rgb888, argb4444, 32'hFFFF_FFFF, MODE_KEY, 8'd255);
        push_pair(32'hFFFF_FFFF, 32'h1234_5678);
        push_pair(32'hFFFF_FFFE, 32'h0000_0000);
        push_pair(32'h0000_0000, 32'hFFFF_FFFF);

        // widths above 8 and shifts of 31: fields run off the top of the word
        settle();
        load_setup({LAYOUT_W{1'b1}}, argb1555, 32'h0000_0000, MODE_KEY_BLEND, 8'h40);
        push_pair(32'hFFFF_FFFF, 32'h0000_7FFF);
        push_pair(32'h7FFF_FFFF, 32'h0000_0000);
        push_pair(32'h0000_0000, 32'hFFFF_FFFF);

        // plain format conversion, missing destination field
        settle();
        load_setup(argb1555, rgb565, 32'h0000_0000, MODE_COPY, 8'd255);
        push_pair(32'hFFFF_FFFF, 32'h0000_0000);
        push_pair(32'h0000_7C1F, 32'hFFFF_FFFF);

        // random register setups with random pixels
        for (int p = 0; p < 6; p++)
        begin
            settle();
            sl = pick_fmt();
            dl = ($urandom_range(3) == 0) ? sl : pick_fmt();
            case ($urandom_range(3))
                0:       alpha = 8'd0;
                1:       alpha = OPAQUE;
                default: alpha = 8'($urandom);
            endcase
            key = ($urandom_range(4) == 0) ? {32{1'($urandom)}} : $urandom;
            load_setup(sl, dl, key, 2'($urandom_range(3)), alpha);
            for (int i = 0; i < 205; i++)
            begin
                src = $urandom;
                case ($urandom_range(9))
                    0, 1:    src = key_reg;
                    2:       src = with_alpha(src, 8'd0);
                    3:       src = with_alpha(src, OPAQUE);
                    default: ;
                endcase
                push_pair(src, $urandom);
            end
        end

        settle();
        if (pixel_results_q.size() != 0 || pixel_pairs_q.size() != 0)
        begin
            $display("%0d results still expected, %0d requests never sent",
                     pixel_results_q.size(), pixel_pairs_q.size());
            error_count++;
        end
        $display("Checked %0d pixels (%0d written, %0d dropped) over %0d register setups.",
                 pixels_checked, pixels_written, pixels_checked - pixels_written, setup_count);
        $display({"Setups mixed copy, color key, blending and layout changes ",
                  "under input and output stalls."});
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
